// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker of the block store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_AT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define LBS_ASSERT(lbl, prop, msg) `ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

// ===== hdl/lbs_pkg.sv =====
// Package with the types, constants and codes of the linked block store.
`timescale 1ns / 1ps
package lbs_pkg;
	localparam int MAX_BLOCKS = 128;
	localparam int MAX_BLOCK_BYTES = 16;
	localparam int BLK_W = $clog2(MAX_BLOCKS);
	localparam int OFF_W = $clog2(MAX_BLOCK_BYTES);
	localparam int DATA_DEPTH = MAX_BLOCKS * MAX_BLOCK_BYTES;
	localparam int DADDR_W = BLK_W + OFF_W;
	localparam int LINK_W = 8;
	localparam int BB_W = 5;
	localparam int CNT_W = 8;
	localparam int POS_W = 11;
	localparam int MAG_W = 12;

	localparam logic [LINK_W-1:0] NONE_LINK = 8'hFF;
	localparam logic [POS_W-1:0] POS_MAX = 11'h7FF;
	localparam logic [BB_W-1:0] BB_RST = 5'd10;
	localparam logic [CNT_W-1:0] CNT_RST = 8'd128;
	localparam logic [BB_W-1:0] BB_MAX = BB_W'(MAX_BLOCK_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

	localparam logic [2:0] KIND_ALLOC = 3'd0;
	localparam logic [2:0] KIND_FREE = 3'd1;
	localparam logic [2:0] KIND_OPEN = 3'd2;
	localparam logic [2:0] KIND_READ = 3'd3;
	localparam logic [2:0] KIND_WRITE = 3'd4;
	localparam logic [2:0] KIND_SEEK = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_END = 2'd2;
	localparam logic [1:0] ST_NO_SPACE = 2'd3;

	localparam logic CFG_BLOCK_BYTES = 1'b0;
	localparam logic CFG_BLOCKS_IN_USE = 1'b1;

	typedef enum logic [2:0] {
		OP_NOP, OP_ALLOC, OP_FREE, OP_OPEN, OP_READ, OP_WRITE, OP_SEEK
	} lbs_op_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] region;
		logic [7:0] write_byte;
		logic signed [11:0] offset;
	} lbs_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] new_region;
		logic [7:0] read_byte;
		logic transferred;
		logic [10:0] position;
	} lbs_out_t;

	typedef struct packed {
		lbs_op_t op;
		logic [LINK_W-1:0] region;
		logic [7:0] wbyte;
		logic seek_neg;
		logic [MAG_W-1:0] seek_mag;
	} lbs_cmd_t;

	typedef struct packed {
		logic valid;
		lbs_cmd_t cmd;
	} lbs_fq_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} lbs_bctl_t;
endpackage

// ===== hdl/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/lbs_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module lbs_front import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input lbs_in_t cmd,
	output lbs_fq_t fq,
	input lbs_bctl_t bctl
);
	lbs_cmd_t q_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	lbs_cmd_t cls;
	logic acc;

	always_comb begin
		case (cmd.kind)
			KIND_ALLOC: cls.op = OP_ALLOC;
			KIND_FREE: cls.op = OP_FREE;
			KIND_OPEN: cls.op = OP_OPEN;
			KIND_READ: cls.op = OP_READ;
			KIND_WRITE: cls.op = OP_WRITE;
			KIND_SEEK: cls.op = OP_SEEK;
			default: cls.op = OP_NOP;
		endcase
		cls.region = cmd.region;
		cls.wbyte = cmd.write_byte;
		cls.seek_neg = cmd.offset[MAG_W-1];
		cls.seek_mag = cmd.offset[MAG_W-1] ? (~cmd.offset + 12'd1) : cmd.offset;
	end

	assign full = (cnt_q == 2'd2) || bctl.clearing;
	assign acc = push && !full;
	assign fq.valid = (cnt_q != 2'd0);
	assign fq.cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				q_q[wr_q] <= cls;
				wr_q <= ~wr_q;
			end
			if (bctl.take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, bctl.take};
		end
	end
endmodule

// ===== hdl/lbs_back.sv =====
// Back end: carries out queued items on the block table and data store.
`timescale 1ns / 1ps
module lbs_back import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data,
	input lbs_fq_t fq,
	output lbs_bctl_t bctl,
	output logic empty,
	input logic pop,
	output lbs_out_t rsp
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_NORM, S_NORM_WT, S_SCAN, S_AL_WR, S_AL_LINK,
		S_FREE_RD, S_FREE_WT, S_RD_CHK, S_RD_WT, S_WR_CHK, S_WR_DO, S_WR_POST,
		S_SKP, S_SKN, S_SKN_WT, S_POS, S_FINISH
	} state_t;

	typedef enum logic [1:0] {LM_ALLOC, LM_PRE, LM_POST} link_mode_t;

	state_t state_q;
	state_t ret_q;
	link_mode_t lm_q;
	lbs_cmd_t cmd_q;
	logic [BLK_W-1:0] cur_q;
	logic [OFF_W-1:0] off_q;
	logic exh_q;
	logic [POS_W-1:0] pos_q;
	logic [BB_W-1:0] bb_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic [LINK_W-1:0] scan_q;
	logic [CNT_W-1:0] steps_q;
	logic [BLK_W-1:0] n_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] moved_q;
	logic [1:0] st_q;
	logic [7:0] nr_q;
	logic [7:0] rb_q;
	logic xf_q;
	logic [DADDR_W-1:0] clr_q;
	lbs_out_t oq_q [2];
	logic ow_q;
	logic or_q;
	logic [1:0] ocnt_q;

	logic [BB_W-1:0] eff_bb;
	logic [CNT_W-1:0] eff_cnt;
	logic [OFF_W-1:0] bb_m1;
	logic off_ge_bb;
	logic step_last;
	logic [BB_W-1:0] avail;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W+1:0] pos_sum;
	logic clr_links;
	logic opush;
	logic opop;

	logic d_we;
	logic [DADDR_W-1:0] d_wa;
	logic [7:0] d_wd;
	logic [DADDR_W-1:0] d_ra;
	logic [7:0] d_rd;
	logic n_we;
	logic [BLK_W-1:0] n_wa;
	logic [LINK_W-1:0] n_wd;
	logic [BLK_W-1:0] n_ra;
	logic [LINK_W-1:0] n_rd;
	logic p_we;
	logic [BLK_W-1:0] p_wa;
	logic [LINK_W-1:0] p_wd;
	logic [LINK_W-1:0] p_rd;

	assign cfg_ready = 1'b1;
	assign eff_bb = (bb_q == '0) ? BB_W'(1) : ((bb_q > BB_MAX) ? BB_MAX : bb_q);
	assign eff_cnt = (cnt_q == '0) ? CNT_W'(1) : ((cnt_q > CNT_MAX) ? CNT_MAX : cnt_q);
	assign bb_m1 = OFF_W'(eff_bb - BB_W'(1));
	assign off_ge_bb = BB_W'(off_q) >= eff_bb;
	assign step_last = (BB_W'(off_q) + BB_W'(1)) >= eff_bb;
	assign avail = eff_bb - BB_W'(off_q);
	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	assign pos_sum = (POS_W+2)'(pos_q) + (POS_W+2)'(moved_q);
	assign clr_links = clr_q < DADDR_W'(MAX_BLOCKS);
	assign opush = (state_q == S_FINISH);
	assign opop = pop && (ocnt_q != 2'd0);
	assign empty = (ocnt_q == 2'd0);
	assign rsp = oq_q[or_q];
	assign bctl.take = (state_q == S_IDLE) && fq.valid && (ocnt_q != 2'd2);
	assign bctl.clearing = (state_q == S_CLEAR);

	always_comb begin
		d_we = (state_q == S_CLEAR) || (state_q == S_WR_DO);
		d_wa = (state_q == S_CLEAR) ? clr_q : {cur_q, off_q};
		d_wd = (state_q == S_CLEAR) ? 8'd0 : cmd_q.wbyte;
		d_ra = {cur_q, off_q};
		n_we = 1'b0;
		n_wa = cur_q;
		n_wd = NONE_LINK;
		n_ra = (state_q == S_FREE_RD) ? scan_q[BLK_W-1:0] : cur_q;
		p_we = 1'b0;
		p_wa = n_q;
		p_wd = NONE_LINK;
		case (state_q)
			S_CLEAR: begin
				n_we = clr_links;
				n_wa = clr_q[BLK_W-1:0];
				p_we = clr_links;
				p_wa = clr_q[BLK_W-1:0];
			end
			S_AL_WR: begin
				n_we = 1'b1;
				n_wa = n_q;
				p_we = 1'b1;
				p_wd = (lm_q == LM_ALLOC) ? NONE_LINK : LINK_W'(cur_q);
			end
			S_AL_LINK: begin
				n_we = 1'b1;
				n_wd = LINK_W'(n_q);
			end
			S_FREE_WT: begin
				n_we = 1'b1;
				n_wa = scan_q[BLK_W-1:0];
				p_we = 1'b1;
				p_wa = scan_q[BLK_W-1:0];
			end
			default: begin
			end
		endcase
	end

	lbs_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
	);

	lbs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_next (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
	);

	lbs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(cur_q), .rdata(p_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_FINISH;
			lm_q <= LM_ALLOC;
			cur_q <= '0;
			off_q <= '0;
			exh_q <= 1'b0;
			pos_q <= '0;
			bb_q <= BB_RST;
			cnt_q <= CNT_RST;
			used_q <= MAX_BLOCKS'(1);
			clr_q <= '0;
			ow_q <= 1'b0;
			or_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_BLOCK_BYTES: bb_q <= cfg_data[BB_W-1:0];
					CFG_BLOCKS_IN_USE: cnt_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (opush) begin
				oq_q[ow_q] <= '{status: st_q, new_region: nr_q, read_byte: rb_q,
					transferred: xf_q, position: pos_q};
				ow_q <= ~ow_q;
			end
			if (opop) begin
				or_q <= ~or_q;
			end
			ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + DADDR_W'(1);
					if (clr_q == DADDR_W'(DATA_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (bctl.take) begin
						cmd_q <= fq.cmd;
						st_q <= ST_OK;
						nr_q <= NONE_LINK;
						rb_q <= 8'd0;
						xf_q <= 1'b0;
						rem_q <= fq.cmd.seek_mag;
						moved_q <= '0;
						case (fq.cmd.op)
							OP_ALLOC: begin
								lm_q <= LM_ALLOC;
								scan_q <= LINK_W'(1);
								state_q <= S_SCAN;
							end
							OP_FREE: begin
								if (fq.cmd.region >= eff_cnt) begin
									st_q <= ST_END;
									state_q <= S_FINISH;
								end else begin
									scan_q <= fq.cmd.region;
									steps_q <= '0;
									state_q <= S_FREE_RD;
								end
							end
							OP_OPEN: begin
								if (fq.cmd.region >= eff_cnt) begin
									st_q <= ST_END;
								end else begin
									cur_q <= fq.cmd.region[BLK_W-1:0];
									off_q <= '0;
									exh_q <= 1'b0;
									pos_q <= '0;
								end
								state_q <= S_FINISH;
							end
							OP_READ: begin
								ret_q <= S_RD_CHK;
								state_q <= S_NORM;
							end
							OP_WRITE: begin
								ret_q <= S_WR_CHK;
								state_q <= S_NORM;
							end
							OP_SEEK: begin
								if (fq.cmd.seek_mag == '0) begin
									state_q <= S_FINISH;
								end else if (fq.cmd.seek_neg) begin
									if (off_ge_bb) begin
										off_q <= bb_m1;
										exh_q <= 1'b1;
									end
									state_q <= S_SKN;
								end else begin
									ret_q <= S_SKP;
									state_q <= S_NORM;
								end
							end
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_NORM: begin
					if (exh_q || off_ge_bb) begin
						if (off_ge_bb) begin
							off_q <= bb_m1;
						end
						exh_q <= 1'b1;
						state_q <= S_NORM_WT;
					end else begin
						state_q <= ret_q;
					end
				end
				S_NORM_WT: begin
					if (n_rd < eff_cnt) begin
						cur_q <= n_rd[BLK_W-1:0];
						off_q <= '0;
						exh_q <= 1'b0;
					end
					state_q <= ret_q;
				end
				S_SCAN: begin
					if (scan_q >= eff_cnt) begin
						case (lm_q)
							LM_ALLOC: st_q <= ST_NO_FREE;
							LM_PRE: st_q <= ST_NO_SPACE;
							default: begin
							end
						endcase
						state_q <= S_FINISH;
					end else if (!used_q[scan_q[BLK_W-1:0]]) begin
						n_q <= scan_q[BLK_W-1:0];
						state_q <= S_AL_WR;
					end else begin
						scan_q <= scan_q + LINK_W'(1);
					end
				end
				S_AL_WR: begin
					used_q[n_q] <= 1'b1;
					if (lm_q == LM_ALLOC) begin
						nr_q <= LINK_W'(n_q);
						state_q <= S_FINISH;
					end else begin
						state_q <= S_AL_LINK;
					end
				end
				S_AL_LINK: begin
					cur_q <= n_q;
					off_q <= '0;
					exh_q <= 1'b0;
					state_q <= (lm_q == LM_PRE) ? S_WR_DO : S_FINISH;
				end
				S_FREE_RD: begin
					if (scan_q < eff_cnt && steps_q < CNT_MAX) begin
						state_q <= S_FREE_WT;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FREE_WT: begin
					if (scan_q != '0) begin
						used_q[scan_q[BLK_W-1:0]] <= 1'b0;
					end
					scan_q <= n_rd;
					steps_q <= steps_q + CNT_W'(1);
					state_q <= S_FREE_RD;
				end
				S_RD_CHK: begin
					if (exh_q) begin
						st_q <= ST_END;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_RD_WT;
					end
				end
				S_RD_WT: begin
					rb_q <= d_rd;
					xf_q <= 1'b1;
					pos_q <= pos_inc;
					if (step_last) begin
						exh_q <= 1'b1;
						ret_q <= S_FINISH;
						state_q <= S_NORM;
					end else begin
						off_q <= off_q + OFF_W'(1);
						state_q <= S_FINISH;
					end
				end
				S_WR_CHK: begin
					if (exh_q) begin
						lm_q <= LM_PRE;
						scan_q <= LINK_W'(1);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_WR_DO;
					end
				end
				S_WR_DO: begin
					xf_q <= 1'b1;
					pos_q <= pos_inc;
					if (step_last) begin
						exh_q <= 1'b1;
						ret_q <= S_WR_POST;
						state_q <= S_NORM;
					end else begin
						off_q <= off_q + OFF_W'(1);
						state_q <= S_FINISH;
					end
				end
				S_WR_POST: begin
					if (exh_q) begin
						lm_q <= LM_POST;
						scan_q <= LINK_W'(1);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SKP: begin
					if (exh_q) begin
						state_q <= S_POS;
					end else if (rem_q < MAG_W'(avail)) begin
						off_q <= off_q + rem_q[OFF_W-1:0];
						moved_q <= moved_q + rem_q;
						rem_q <= '0;
						state_q <= S_POS;
					end else begin
						moved_q <= moved_q + MAG_W'(avail);
						rem_q <= rem_q - MAG_W'(avail);
						off_q <= bb_m1;
						exh_q <= 1'b1;
						if (rem_q == MAG_W'(avail)) begin
							state_q <= S_POS;
						end else begin
							ret_q <= S_SKP;
							state_q <= S_NORM;
						end
					end
				end
				S_SKN: begin
					if (rem_q == '0) begin
						state_q <= S_POS;
					end else if (exh_q) begin
						exh_q <= 1'b0;
						off_q <= bb_m1;
						rem_q <= rem_q - MAG_W'(1);
						moved_q <= moved_q + MAG_W'(1);
					end else if (rem_q <= MAG_W'(off_q)) begin
						off_q <= off_q - rem_q[OFF_W-1:0];
						moved_q <= moved_q + rem_q;
						rem_q <= '0;
						state_q <= S_POS;
					end else begin
						moved_q <= moved_q + MAG_W'(off_q);
						rem_q <= rem_q - MAG_W'(off_q);
						off_q <= '0;
						state_q <= S_SKN_WT;
					end
				end
				S_SKN_WT: begin
					if (p_rd >= eff_cnt) begin
						state_q <= S_POS;
					end else begin
						cur_q <= p_rd[BLK_W-1:0];
						off_q <= bb_m1;
						rem_q <= rem_q - MAG_W'(1);
						moved_q <= moved_q + MAG_W'(1);
						state_q <= S_SKN;
					end
				end
				S_POS: begin
					if (rem_q != '0) begin
						st_q <= ST_END;
					end
					if (cmd_q.seek_neg) begin
						pos_q <= (moved_q >= MAG_W'(pos_q)) ? '0 : pos_q - moved_q[POS_W-1:0];
					end else begin
						pos_q <= (pos_sum > (POS_W+2)'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];
					end
					state_q <= S_FINISH;
				end
				S_FINISH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/linked_block_store.sv =====
// A write that fills or runs past its block links a new block found by scanning the used
// marks from block 1 up; allocate scans the used marks one block a cycle, free walks its
// chain block by block, and seeks move block by block along the links. One item is
// carried out at a time; the result queue holds two results. After reset the data store
// and links are cleared while full stays high.
`timescale 1ns / 1ps
module linked_block_store import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input lbs_in_t cmd,
	output logic empty,
	input logic pop,
	output lbs_out_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data
);
	lbs_fq_t fq;
	lbs_bctl_t bctl;

	lbs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.fq(fq), .bctl(bctl)
	);

	lbs_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fq(fq), .bctl(bctl),
		.empty(empty), .pop(pop), .rsp(rsp)
	);
endmodule

// ===== hdl/lbs_checker.sv =====
// Port-level checker of the linked block store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbs_checker import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input lbs_in_t cmd,
	input logic empty,
	input logic pop,
	input lbs_out_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data
);
	`LBS_ASSERT(a_xfer_ok, !empty && rsp.transferred |-> rsp.status == ST_OK && rsp.new_region == NONE_LINK, "transfer with bad status")
	`LBS_ASSERT(a_alloc_ok, !empty && rsp.new_region != NONE_LINK |-> rsp.status == ST_OK && !rsp.transferred && rsp.new_region != 8'd0, "bad allocate result")
	`LBS_ASSERT(a_read_xfer, !empty && rsp.read_byte != 8'd0 |-> rsp.transferred, "read byte without transfer")
	`LBS_ASSERT(a_rsp_hold, !empty && !pop |=> !empty && $stable(rsp), "result dropped while stalled")
endmodule

bind linked_block_store lbs_checker u_lbs_checker (.*);

// ===== tb/linked_block_store_checker.sv =====
// Checker that predicts the block store's results and compares them with the outputs.
`timescale 1ns / 1ps
module linked_block_store_checker import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input lbs_in_t cmd,
	input logic empty,
	input logic pop,
	input lbs_out_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data,
	output int failures
);
	logic used_mark [MAX_BLOCKS];
	logic [7:0] back_link [MAX_BLOCKS];
	logic [7:0] fwd_link [MAX_BLOCKS];
	logic [7:0] store_bytes [DATA_DEPTH];
	int cur_blk;
	int cur_off;
	bit cur_done;
	int cur_pos;
	logic [4:0] bytes_reg;
	logic [7:0] count_reg;
	lbs_out_t awaited_rsp [$];
	int mismatches;

	function automatic int block_len();
		int b;
		b = bytes_reg;
		if (b < 1) b = 1;
		if (b > MAX_BLOCK_BYTES) b = MAX_BLOCK_BYTES;
		return b;
	endfunction

	function automatic int pool_len();
		int c;
		c = count_reg;
		if (c < 1) c = 1;
		if (c > MAX_BLOCKS) c = MAX_BLOCKS;
		return c;
	endfunction

	function automatic void clip_offset();
		if (cur_off >= block_len()) begin
			cur_off = block_len() - 1;
			cur_done = 1'b1;
		end
	endfunction

	function automatic void follow_next();
		clip_offset();
		if (cur_done && fwd_link[cur_blk] < pool_len()) begin
			cur_blk = fwd_link[cur_blk];
			cur_off = 0;
			cur_done = 1'b0;
		end
	endfunction

	function automatic int take_block(int prev);
		for (int i = 1; i < pool_len(); i++) begin
			if (!used_mark[i]) begin
				used_mark[i] = 1'b1;
				back_link[i] = 8'(prev);
				fwd_link[i] = NONE_LINK;
				return i;
			end
		end
		return NONE_LINK;
	endfunction

	function automatic bit extend_chain();
		int n;
		n = take_block(cur_blk);
		if (n == NONE_LINK) return 1'b0;
		fwd_link[cur_blk] = 8'(n);
		cur_blk = n;
		cur_off = 0;
		cur_done = 1'b0;
		return 1'b1;
	endfunction

	function automatic void advance();
		if (cur_off + 1 < block_len()) cur_off++;
		else begin
			cur_done = 1'b1;
			follow_next();
		end
	endfunction

	function automatic lbs_out_t predict_result(lbs_in_t it);
		int bb, cnt, rem, moved, avail, b, nx, steps, p;
		lbs_out_t r;
		bb = block_len();
		cnt = pool_len();
		r.status = ST_OK;
		r.new_region = NONE_LINK;
		r.read_byte = '0;
		r.transferred = 1'b0;
		case (it.kind)
			KIND_ALLOC: begin
				p = take_block(NONE_LINK);
				if (p == NONE_LINK) r.status = ST_NO_FREE;
				else r.new_region = 8'(p);
			end
			KIND_FREE: begin
				if (it.region >= cnt) r.status = ST_END;
				else begin
					b = it.region;
					steps = 0;
					while (b < cnt && steps < MAX_BLOCKS) begin
						nx = fwd_link[b];
						if (b != 0) used_mark[b] = 1'b0;
						back_link[b] = NONE_LINK;
						fwd_link[b] = NONE_LINK;
						b = nx;
						steps++;
					end
				end
			end
			KIND_OPEN: begin
				if (it.region >= cnt) r.status = ST_END;
				else begin
					cur_blk = it.region;
					cur_off = 0;
					cur_done = 1'b0;
					cur_pos = 0;
				end
			end
			KIND_READ: begin
				follow_next();
				if (cur_done) r.status = ST_END;
				else begin
					r.read_byte = store_bytes[cur_blk * MAX_BLOCK_BYTES + cur_off];
					advance();
					r.transferred = 1'b1;
					cur_pos = (cur_pos + 1 > POS_MAX) ? POS_MAX : cur_pos + 1;
				end
			end
			KIND_WRITE: begin
				follow_next();
				if (cur_done && !extend_chain()) r.status = ST_NO_SPACE;
				else begin
					store_bytes[cur_blk * MAX_BLOCK_BYTES + cur_off] = it.write_byte;
					advance();
					if (cur_done) void'(extend_chain());
					r.transferred = 1'b1;
					cur_pos = (cur_pos + 1 > POS_MAX) ? POS_MAX : cur_pos + 1;
				end
			end
			KIND_SEEK: begin
				moved = 0;
				if (it.offset > 0) begin
					rem = it.offset;
					while (rem > 0) begin
						follow_next();
						if (cur_done) break;
						avail = bb - cur_off;
						if (rem < avail) begin
							cur_off += rem;
							moved += rem;
							rem = 0;
						end else begin
							moved += avail;
							rem -= avail;
							cur_off = bb - 1;
							cur_done = 1'b1;
						end
					end
					if (rem > 0) r.status = ST_END;
					cur_pos = (cur_pos + moved > POS_MAX) ? POS_MAX : cur_pos + moved;
				end else if (it.offset < 0) begin
					rem = -int'(it.offset);
					clip_offset();
					while (rem > 0) begin
						if (cur_done) begin
							cur_done = 1'b0;
							cur_off = bb - 1;
							rem--;
							moved++;
						end else if (rem <= cur_off) begin
							cur_off -= rem;
							moved += rem;
							rem = 0;
						end else begin
							moved += cur_off;
							rem -= cur_off;
							cur_off = 0;
							p = back_link[cur_blk];
							if (p >= cnt) break;
							cur_blk = p;
							cur_off = bb - 1;
							rem--;
							moved++;
						end
					end
					if (rem > 0) r.status = ST_END;
					cur_pos = (moved >= cur_pos) ? 0 : cur_pos - moved;
				end
			end
			default: ;
		endcase
		r.position = 11'(cur_pos);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lbs_out_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				used_mark[i] = (i == 0);
				back_link[i] = NONE_LINK;
				fwd_link[i] = NONE_LINK;
			end
			for (int i = 0; i < DATA_DEPTH; i++) store_bytes[i] = '0;
			cur_blk = 0;
			cur_off = 0;
			cur_done = 1'b0;
			cur_pos = 0;
			bytes_reg = BB_RST;
			count_reg = CNT_RST;
			awaited_rsp.delete();
			mismatches = 0;
		end else begin
			if (pop && !empty) begin
				if (awaited_rsp.size() == 0) begin
					$error("result transfer with no expected result");
					mismatches++;
				end else begin
					exp_r = awaited_rsp.pop_front();
					if (rsp.status !== exp_r.status) begin
						$error("status expected %0d actual %0d", exp_r.status, rsp.status);
						mismatches++;
					end
					if (rsp.new_region !== exp_r.new_region) begin
						$error("new_region expected %0d actual %0d",
							exp_r.new_region, rsp.new_region);
						mismatches++;
					end
					if (rsp.read_byte !== exp_r.read_byte) begin
						$error("read_byte expected %0d actual %0d",
							exp_r.read_byte, rsp.read_byte);
						mismatches++;
					end
					if (rsp.transferred !== exp_r.transferred) begin
						$error("transferred expected %0d actual %0d",
							exp_r.transferred, rsp.transferred);
						mismatches++;
					end
					if (rsp.position !== exp_r.position) begin
						$error("position expected %0d actual %0d",
							exp_r.position, rsp.position);
						mismatches++;
					end
				end
			end
			if (push && !full) awaited_rsp.push_back(predict_result(cmd));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BLOCK_BYTES) bytes_reg = cfg_data[4:0];
				else count_reg = cfg_data;
			end
		end
		failures <= mismatches + awaited_rsp.size();
	end
endmodule

// ===== tb/linked_block_store_tb.sv =====
// Top of the block store testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module linked_block_store_tb import lbs_pkg::*;;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	lbs_in_t cmd = '0;
	logic empty;
	logic pop = 1'b0;
	lbs_out_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_BLOCK_BYTES;
	logic [7:0] cfg_data = '0;
	int failures;
	int sent_items = 0;
	int taken_results = 0;
	int send_idle = 26;
	int recv_idle = 45;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int cur_count = 128;
	int cur_bytes = 10;

	always #1 clk = ~clk;

	linked_block_store u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.empty(empty), .pop(pop), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	linked_block_store_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.empty(empty), .pop(pop), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures)
	);

	// The receiver honors a long hold-off when asked, so the block fills and stalls.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) taken_results++;
		if (hold_req) begin
			hold_left = 600;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_item(lbs_in_t it);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= it;
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
		sent_items++;
	endtask

	task automatic send_op(logic [2:0] k, logic [7:0] reg_id, logic [7:0] wb,
		logic signed [11:0] ofs);
		lbs_in_t it;
		it.kind = k;
		it.region = reg_id;
		it.write_byte = wb;
		it.offset = ofs;
		send_item(it);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BLOCK_BYTES) cur_bytes = (val[4:0] < 1) ? 1 :
			(val[4:0] > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : val[4:0];
		else cur_count = (val < 1) ? 1 : (val > MAX_BLOCKS) ? MAX_BLOCKS : val;
		@(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (taken_results != sent_items) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic lbs_in_t random_op();
		lbs_in_t it;
		int w;
		w = $urandom_range(99);
		if (w < 14) it.kind = KIND_ALLOC;
		else if (w < 22) it.kind = KIND_FREE;
		else if (w < 33) it.kind = KIND_OPEN;
		else if (w < 53) it.kind = KIND_READ;
		else if (w < 84) it.kind = KIND_WRITE;
		else if (w < 97) it.kind = KIND_SEEK;
		else it.kind = 3'($urandom_range(6, 7));
		w = $urandom_range(99);
		if (w < 80) it.region = 8'($urandom_range(0, cur_count));
		else if (w < 90) it.region = NONE_LINK;
		else it.region = 8'($urandom);
		it.write_byte = 8'($urandom);
		if ($urandom_range(99) < 4) it.offset = 12'($urandom);
		else it.offset = 12'($urandom_range(0, 6 * cur_bytes)) - 12'(3 * cur_bytes);
		return it;
	endfunction

	task automatic random_phase(logic [7:0] bytes_val, logic [7:0] count_val,
		int s_idle, int r_idle, int n, bit with_hold);
		write_reg(CFG_BLOCK_BYTES, bytes_val);
		write_reg(CFG_BLOCKS_IN_USE, count_val);
		send_idle = s_idle;
		recv_idle = r_idle;
		if (with_hold) hold_req = 1'b1;
		for (int i = 0; i < n; i++) send_item(random_op());
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);

		// Two blocks of two bytes: exhausts the pool, chain ends, bad regions.
		write_reg(CFG_BLOCK_BYTES, 8'd2);
		write_reg(CFG_BLOCKS_IN_USE, 8'd3);
		send_op(KIND_ALLOC, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_ALLOC, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_ALLOC, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_OPEN, 8'd1, 8'd0, 12'sd0);
		send_op(KIND_WRITE, 8'd0, 8'hA5, 12'sd0);
		send_op(KIND_WRITE, 8'd0, 8'hFF, 12'sd0);
		send_op(KIND_WRITE, 8'd0, 8'h00, 12'sd0);
		send_op(KIND_READ, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_SEEK, 8'd0, 8'd0, -12'sd1);
		send_op(KIND_READ, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_SEEK, 8'd0, 8'd0, 12'sd5);
		send_op(KIND_SEEK, 8'd0, 8'd0, -12'sd2048);
		send_op(KIND_SEEK, 8'd0, 8'd0, 12'sd2047);
		send_op(KIND_SEEK, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_OPEN, NONE_LINK, 8'd0, 12'sd0);
		send_op(KIND_FREE, 8'd200, 8'd0, 12'sd0);
		send_op(KIND_FREE, 8'd1, 8'd0, 12'sd0);
		send_op(KIND_OPEN, 8'd2, 8'd0, 12'sd0);
		send_op(KIND_READ, 8'd0, 8'd0, 12'sd0);
		send_op(3'd6, 8'd0, 8'd0, 12'sd0);
		send_op(3'd7, 8'hFF, 8'hFF, -12'sd1);
		send_op(KIND_FREE, 8'd0, 8'd0, 12'sd0);
		send_op(KIND_WRITE, 8'd0, 8'h5A, 12'sd0);
		drain();

		random_phase(8'd16, 8'd128, 26, 45, 500, 1'b0);
		random_phase(8'd1, 8'd6, 45, 26, 400, 1'b1);
		random_phase(8'd31, 8'd0, 45, 26, 30, 1'b0);
		random_phase(8'd4, 8'd255, 0, 0, 500, 1'b0);
		random_phase(8'd0, 8'd16, 0, 0, 400, 1'b0);
		repeat (20) @(posedge clk);

		if (failures == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
